// ===== design/flash_image_packetizer_defines.svh =====
// Assertion macros shared by the checker of the flash image packetizer.
`ifndef FLASH_IMAGE_PACKETIZER_DEFINES_SVH
`define FLASH_IMAGE_PACKETIZER_DEFINES_SVH

// Same-cycle implication, sampled on the rising edge and held off while the given reset is low.
`define FIP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge and held off while the given reset is low.
`define FIP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fip_pkg.sv =====
`default_nettype none

package fip_pkg;

  localparam int BYTES_PER_PACKET = 8;
  localparam int BYTES_PER_ROW    = 32;
  localparam int PACKETS_PER_ROW  = (BYTES_PER_ROW / BYTES_PER_PACKET) > 0 ?
                                    (BYTES_PER_ROW / BYTES_PER_PACKET) : 1;

  localparam int POS_W  = 17;
  localparam int IDX_W  = BYTES_PER_PACKET > 1 ? $clog2(BYTES_PER_PACKET) : 1;
  localparam int VCNT_W = $clog2(BYTES_PER_PACKET + 1);
  localparam int ROW_W  = PACKETS_PER_ROW > 1 ? $clog2(PACKETS_PER_ROW) : 1;

  localparam int HDR_LEN = 5;
  localparam int PKT_LEN = BYTES_PER_PACKET + HDR_LEN;
  localparam int CRC_LEN = 11;
  localparam int MAX_LEN = PKT_LEN > CRC_LEN ? PKT_LEN : CRC_LEN;
  localparam int CNT_W   = $clog2(MAX_LEN);

  localparam logic [7:0]  WR_LEN_BYTE  = 8'(BYTES_PER_PACKET + 4);
  localparam logic [7:0]  CRC_LEN_BYTE = 8'd10;
  localparam logic [7:0]  PAD_BYTE     = 8'hFF;
  localparam logic [7:0]  ODD_MASK     = 8'h3F;
  localparam logic [31:0] CRC_POLY     = 32'h04C11DB7;
  localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_OPCODE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_OPCODE     = 2'd3;

  typedef struct packed {
    logic [7:0] image_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       packet_end;
    logic       run_end;
  } out_item_t;

  typedef struct packed {
    logic [7:0]       target_address;
    logic [POS_W-1:0] start_offset;
    logic [7:0]       flash_opcode;
    logic [7:0]       crc_opcode;
  } cfg_t;

  // One write packet for the back end, plus the closing details when it ends the image.
  typedef struct packed {
    logic [BYTES_PER_PACKET-1:0][7:0] data;
    logic [VCNT_W-1:0]                vcnt;
    logic [POS_W-1:0]                 base;
    logic                             last;
    logic [ROW_W-1:0]                 pads;
    logic [31:0]                      crc;
    logic [15:0]                      size;
  } job_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WRITE,
    PH_CRC
  } phase_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {b, 24'h000000};
    for (int k = 0; k < 8; k++) begin
      r = r[31] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/flash_image_packetizer.sv =====
// Flash image packetizer: takes a firmware image one byte per item and sends framed
// flash-write packets out as a byte stream, one byte per cycle while out_ready is high.
// The front end takes an image byte in every cycle while its two-entry packet queue has
// room; each full group of eight bytes (or the final byte) queues one write packet. The
// back end emits 13 bytes per write packet, so in steady state the single-byte output
// sequencer sets the pace. The final byte causes its own packet, write packets with
// all-0xFF data up to the end of the 32-byte row and an 11-byte CRC packet, up to 63
// bytes. Configuration writes are always taken and should be made while the block is idle.
`default_nettype none

module flash_image_packetizer (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire fip_pkg::in_item_t                  in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output fip_pkg::out_item_t                      out_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [fip_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [fip_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  fip_pkg::cfg_t cfg_r, cfg_nxt;
  fip_pkg::job_t push_data, pop_data;
  logic          push, push_ready, pop, pop_valid;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        fip_pkg::REG_TARGET_ADDRESS: cfg_nxt.target_address = cfg_wdata[7:0];
        fip_pkg::REG_START_OFFSET:   cfg_nxt.start_offset   = cfg_wdata[fip_pkg::POS_W-1:0];
        fip_pkg::REG_FLASH_OPCODE:   cfg_nxt.flash_opcode   = cfg_wdata[7:0];
        fip_pkg::REG_CRC_OPCODE:     cfg_nxt.crc_opcode     = cfg_wdata[7:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fip_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  fip_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_data   (pop_data),
    .pop_valid  (pop_valid)
  );

  fip_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_data  (pop_data),
    .pop_valid (pop_valid),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== design/fip_fifo.sv =====
`default_nettype none

module fip_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire fip_pkg::job_t push_data,
  output logic               push_ready,
  input  wire logic          pop,
  output fip_pkg::job_t      pop_data,
  output logic               pop_valid
);

  fip_pkg::job_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push && push_ready) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop && pop_valid) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if ((push && push_ready) && !(pop && pop_valid)) begin
      count_nxt = count_r + 2'd1;
    end else if (!(push && push_ready) && (pop && pop_valid)) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/fip_front.sv =====
`default_nettype none

module fip_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire fip_pkg::in_item_t in_data,
  output logic                   push,
  output fip_pkg::job_t          push_data,
  input  wire logic              push_ready
);

  logic [fip_pkg::BYTES_PER_PACKET-1:0][7:0] pend_r, pend_nxt;
  logic [fip_pkg::IDX_W-1:0] fill_r, fill_nxt;
  logic [fip_pkg::ROW_W-1:0] row_r, row_nxt, row_inc;
  logic [fip_pkg::POS_W-1:0] bytes_r, bytes_nxt, bytes_inc;
  logic [31:0]               crc_r, crc_nxt, crc_upd;
  logic [7:0]                crc_in;
  logic                      accept, pkt_done;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    crc_in    = bytes_r[0] ? (in_data.image_byte & fip_pkg::ODD_MASK) : in_data.image_byte;
    crc_upd   = fip_pkg::crc_byte(crc_r, crc_in);
    bytes_inc = bytes_r + fip_pkg::POS_W'(1);
    pkt_done  = (fill_r == fip_pkg::IDX_W'(fip_pkg::BYTES_PER_PACKET - 1)) ||
                in_data.final_byte;
    row_inc   = (row_r == fip_pkg::ROW_W'(fip_pkg::PACKETS_PER_ROW - 1)) ?
                '0 : row_r + fip_pkg::ROW_W'(1);

    pend_nxt         = pend_r;
    pend_nxt[fill_r] = in_data.image_byte;

    push_data.data = pend_nxt;
    push_data.vcnt = fip_pkg::VCNT_W'(fill_r) + fip_pkg::VCNT_W'(1);
    push_data.base = bytes_r - fip_pkg::POS_W'(fill_r);
    push_data.last = in_data.final_byte;
    // Packets still needed to close the row once this one has gone out; only the
    // final byte of an image closes the row.
    push_data.pads = (!in_data.final_byte || row_inc == '0) ? '0 :
                     fip_pkg::ROW_W'(fip_pkg::PACKETS_PER_ROW) - row_inc;
    push_data.crc  = ~crc_upd;
    push_data.size = bytes_inc[15:0];
    push           = accept && pkt_done;

    fill_nxt  = fill_r;
    row_nxt   = row_r;
    bytes_nxt = bytes_r;
    crc_nxt   = crc_r;
    if (accept) begin
      if (in_data.final_byte) begin
        fill_nxt  = '0;
        row_nxt   = '0;
        bytes_nxt = '0;
        crc_nxt   = fip_pkg::CRC_INIT;
      end else begin
        fill_nxt  = pkt_done ? '0 : fill_r + fip_pkg::IDX_W'(1);
        row_nxt   = pkt_done ? row_inc : row_r;
        bytes_nxt = bytes_inc;
        crc_nxt   = crc_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      row_r   <= '0;
      bytes_r <= '0;
      crc_r   <= fip_pkg::CRC_INIT;
    end else begin
      fill_r  <= fill_nxt;
      row_r   <= row_nxt;
      bytes_r <= bytes_nxt;
      crc_r   <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_r <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/fip_back.sv =====
`default_nettype none

module fip_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire fip_pkg::cfg_t cfg,
  input  wire fip_pkg::job_t pop_data,
  input  wire logic          pop_valid,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output fip_pkg::out_item_t out_data
);

  fip_pkg::phase_t           phase_r, phase_nxt;
  logic [fip_pkg::CNT_W-1:0] cnt_r, cnt_nxt, di;
  fip_pkg::job_t             job_r, job_nxt;
  logic                      out_valid_r, out_valid_nxt;
  fip_pkg::out_item_t        out_r, out_nxt;
  logic                      slot_free, emit, end_w, end_c, done;
  logic [fip_pkg::POS_W-1:0] waddr;
  logic [15:0]               word;
  logic [7:0]                byte_w, byte_c;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    slot_free = !out_valid_r || out_ready;
    emit      = (phase_r != fip_pkg::PH_IDLE) && slot_free;
    end_w     = (phase_r == fip_pkg::PH_WRITE) &&
                (cnt_r == fip_pkg::CNT_W'(fip_pkg::PKT_LEN - 1));
    end_c     = (phase_r == fip_pkg::PH_CRC) &&
                (cnt_r == fip_pkg::CNT_W'(fip_pkg::CRC_LEN - 1));
    waddr     = cfg.start_offset + job_r.base;
    word      = waddr[fip_pkg::POS_W-1:1];
    di        = cnt_r - fip_pkg::CNT_W'(fip_pkg::HDR_LEN);

    if (cnt_r == fip_pkg::CNT_W'(0)) begin
      byte_w = cfg.target_address;
    end else if (cnt_r == fip_pkg::CNT_W'(1)) begin
      byte_w = fip_pkg::WR_LEN_BYTE;
    end else if (cnt_r == fip_pkg::CNT_W'(2)) begin
      byte_w = cfg.flash_opcode;
    end else if (cnt_r == fip_pkg::CNT_W'(3)) begin
      byte_w = word[7:0];
    end else if (cnt_r == fip_pkg::CNT_W'(4)) begin
      byte_w = word[15:8];
    end else if (8'(di) < 8'(job_r.vcnt)) begin
      byte_w = job_r.data[di[fip_pkg::IDX_W-1:0]];
    end else begin
      byte_w = fip_pkg::PAD_BYTE;
    end

    unique case (cnt_r)
      fip_pkg::CNT_W'(0):  byte_c = cfg.target_address;
      fip_pkg::CNT_W'(1):  byte_c = fip_pkg::CRC_LEN_BYTE;
      fip_pkg::CNT_W'(2):  byte_c = cfg.crc_opcode;
      fip_pkg::CNT_W'(3):  byte_c = cfg.start_offset[8:1];
      fip_pkg::CNT_W'(4):  byte_c = cfg.start_offset[16:9];
      fip_pkg::CNT_W'(5):  byte_c = job_r.size[7:0];
      fip_pkg::CNT_W'(6):  byte_c = job_r.size[15:8];
      fip_pkg::CNT_W'(7):  byte_c = job_r.crc[7:0];
      fip_pkg::CNT_W'(8):  byte_c = job_r.crc[15:8];
      fip_pkg::CNT_W'(9):  byte_c = job_r.crc[23:16];
      fip_pkg::CNT_W'(10): byte_c = job_r.crc[31:24];
      default:             byte_c = fip_pkg::PAD_BYTE;
    endcase

    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    job_nxt       = job_r;
    done          = (phase_r == fip_pkg::PH_IDLE);

    if (emit) begin
      out_valid_nxt       = 1'b1;
      out_nxt.packet_byte = (phase_r == fip_pkg::PH_CRC) ? byte_c : byte_w;
      out_nxt.packet_end  = end_w || end_c;
      // A write packet closes the item's output only when no padding or CRC follows.
      out_nxt.run_end     = end_c || (end_w && !job_r.last);
      cnt_nxt             = cnt_r + fip_pkg::CNT_W'(1);
      if (end_w) begin
        cnt_nxt = '0;
        if (job_r.pads != '0) begin
          job_nxt.pads = job_r.pads - fip_pkg::ROW_W'(1);
          job_nxt.base = job_r.base + fip_pkg::POS_W'(fip_pkg::BYTES_PER_PACKET);
          job_nxt.vcnt = '0;
        end else if (job_r.last) begin
          phase_nxt = fip_pkg::PH_CRC;
        end else begin
          done = 1'b1;
        end
      end
      if (end_c) begin
        done = 1'b1;
      end
    end

    pop = done && pop_valid;
    if (done) begin
      if (pop_valid) begin
        phase_nxt = fip_pkg::PH_WRITE;
        cnt_nxt   = '0;
        job_nxt   = pop_data;
      end else begin
        phase_nxt = fip_pkg::PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= fip_pkg::PH_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

// ===== design/fip_checker.sv =====
`default_nettype none
`include "flash_image_packetizer_defines.svh"

module fip_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire fip_pkg::out_item_t out_data
);

  // A stalled result item keeps its place and its value.
  `FIP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result item changed while stalled")

  // The output of an item always ends on a packet boundary.
  `FIP_ASSERT_IMP(a_run_on_pkt, clk, rst_n, out_valid && out_data.run_end, out_data.packet_end, "run end without packet end")

  // Nothing is offered in the cycle after reset.
  `FIP_ASSERT_NXT(a_reset_quiet, clk, 1'b1, !rst_n, !out_valid, "result offered straight after reset")

endmodule

bind flash_image_packetizer fip_checker u_fip_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// ===== sim/flash_image_packetizer_tb.sv =====
`default_nettype none

module flash_image_packetizer_tb;

  localparam int SETTLE_CYCLES = 20;
  localparam int STALL_LIMIT   = 2000;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_BYTES  = 220;
  localparam int MAX_IDLE      = 11;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  fip_pkg::in_item_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  fip_pkg::out_item_t             out_data;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [fip_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fip_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predicted register contents and image state.
  logic [7:0]                exp_target;
  logic [fip_pkg::POS_W-1:0] exp_start;
  logic [7:0]                exp_flash_op;
  logic [7:0]                exp_crc_op;
  logic [7:0]                held_bytes [fip_pkg::BYTES_PER_PACKET];
  int unsigned               held_count;
  int unsigned               row_packets;
  logic [fip_pkg::POS_W-1:0] image_pos;
  logic [31:0]               image_crc;

  fip_pkg::out_item_t expected_bytes[$];
  int                 mismatches  = 0;
  int                 idle_cycles = 0;
  int unsigned        stall_left  = 0;
  bit                 tx_fast     = 1'b0;
  bit                 rx_fast     = 1'b0;

  flash_image_packetizer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] crc32_msb_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {b, 24'h000000};
    for (int k = 0; k < 8; k++) begin
      if (r[31]) begin
        r = (r << 1) ^ 32'h04C11DB7;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_image_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [fip_pkg::CFG_DATA_W-1:0] pick_reg_value();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return fip_pkg::CFG_DATA_W'($urandom);
    endcase
  endfunction

  task automatic clear_image();
    held_count  = 0;
    row_packets = 0;
    image_pos   = '0;
    image_crc   = 32'hFFFFFFFF;
  endtask

  task automatic expect_byte(logic [7:0] b, bit last_of_packet);
    fip_pkg::out_item_t e;
    e.packet_byte = b;
    e.packet_end  = last_of_packet;
    e.run_end     = 1'b0;
    expected_bytes = {expected_bytes, e};
  endtask

  task automatic expect_write_packet(logic [fip_pkg::POS_W-1:0] base, int unsigned filled);
    logic [fip_pkg::POS_W:0] sum;
    sum = {1'b0, exp_start} + {1'b0, base};
    expect_byte(exp_target, 1'b0);
    expect_byte(8'(fip_pkg::BYTES_PER_PACKET + 4), 1'b0);
    expect_byte(exp_flash_op, 1'b0);
    expect_byte(sum[8:1], 1'b0);
    expect_byte(sum[16:9], 1'b0);
    for (int i = 0; i < fip_pkg::BYTES_PER_PACKET; i++) begin
      expect_byte((i < filled) ? held_bytes[i] : 8'hFF, i == fip_pkg::BYTES_PER_PACKET - 1);
    end
  endtask

  task automatic predict_image_byte(fip_pkg::in_item_t item);
    logic [fip_pkg::POS_W-1:0] base;
    logic [31:0]               crc_out;
    int unsigned               queued_before;
    fip_pkg::out_item_t        tail;
    queued_before = expected_bytes.size();
    base = image_pos - fip_pkg::POS_W'(held_count);
    // Bytes at odd image positions only contribute their low six bits.
    image_crc = crc32_msb_step(image_crc,
                               image_pos[0] ? (item.image_byte & 8'h3F) : item.image_byte);
    if (held_count < fip_pkg::BYTES_PER_PACKET) begin
      held_bytes[held_count] = item.image_byte;
    end
    held_count++;
    image_pos = image_pos + 1'b1;
    if (held_count >= fip_pkg::BYTES_PER_PACKET || item.final_byte) begin
      expect_write_packet(base, held_count);
      held_count  = 0;
      row_packets = (row_packets + 1) % fip_pkg::PACKETS_PER_ROW;
    end
    if (item.final_byte) begin
      while (row_packets != 0) begin
        base = base + fip_pkg::POS_W'(fip_pkg::BYTES_PER_PACKET);
        expect_write_packet(base, 0);
        row_packets = (row_packets + 1) % fip_pkg::PACKETS_PER_ROW;
      end
      crc_out = ~image_crc;
      expect_byte(exp_target, 1'b0);
      expect_byte(8'd10, 1'b0);
      expect_byte(exp_crc_op, 1'b0);
      expect_byte(exp_start[8:1], 1'b0);
      expect_byte(exp_start[16:9], 1'b0);
      expect_byte(image_pos[7:0], 1'b0);
      expect_byte(image_pos[15:8], 1'b0);
      expect_byte(crc_out[7:0], 1'b0);
      expect_byte(crc_out[15:8], 1'b0);
      expect_byte(crc_out[23:16], 1'b0);
      expect_byte(crc_out[31:24], 1'b1);
      clear_image();
    end
    if (expected_bytes.size() > queued_before) begin
      tail = expected_bytes[expected_bytes.size() - 1];
      tail.run_end = 1'b1;
      expected_bytes[expected_bytes.size() - 1] = tail;
    end
  endtask

  task automatic apply_reg_write(logic [fip_pkg::CFG_IDX_W-1:0] idx,
                                 logic [fip_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      fip_pkg::REG_TARGET_ADDRESS: exp_target   = d[7:0];
      fip_pkg::REG_START_OFFSET:   exp_start    = d[fip_pkg::POS_W-1:0];
      fip_pkg::REG_FLASH_OPCODE:   exp_flash_op = d[7:0];
      fip_pkg::REG_CRC_OPCODE:     exp_crc_op   = d[7:0];
      default: ;
    endcase
  endtask

  task automatic note_mismatch(string what, fip_pkg::out_item_t want,
                               fip_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch (%s): expected byte %02h end %0b run %0b, got byte %02h end %0b run %0b",
               what, want.packet_byte, want.packet_end, want.run_end,
               got.packet_byte, got.packet_end, got.run_end);
    end
  endtask

  always @(posedge clk) begin : result_check
    fip_pkg::out_item_t want;
    bit                 moved;
    moved = 1'b0;
    if (!rst_n) begin
      exp_target   = '0;
      exp_start    = '0;
      exp_flash_op = '0;
      exp_crc_op   = '0;
      clear_image();
      expected_bytes.delete();
      idle_cycles = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        apply_reg_write(cfg_index, cfg_wdata);
        moved = 1'b1;
      end
      if (in_valid && in_ready) begin
        predict_image_byte(in_data);
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (expected_bytes.size() == 0) begin
          note_mismatch("no byte expected", '0, out_data);
        end else begin
          want = expected_bytes.pop_front();
          if (out_data.packet_byte !== want.packet_byte ||
              out_data.packet_end !== want.packet_end ||
              out_data.run_end !== want.run_end) begin
            note_mismatch("wrong field", want, out_data);
          end
        end
        stall_left = rx_fast ? 0 : $urandom_range(0, MAX_IDLE);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // The receiver holds ready low for the stall drawn at the last accepted item.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_image_byte(logic [7:0] b, bit fin);
    int unsigned       gap;
    fip_pkg::in_item_t item;
    gap = tx_fast ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item.image_byte = b;
    item.final_byte = fin;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_image(int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_image_byte(pick_image_byte(), i == len - 1);
    end
  endtask

  // Leaves the block with nothing outstanding, so that registers may be written.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [fip_pkg::CFG_IDX_W-1:0] idx,
                           logic [fip_pkg::CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One byte gives a packet padded to the full row, with register extremes and stray
  // upper bits on the byte-wide registers.
  task automatic test_single_byte_image();
    write_reg(fip_pkg::REG_TARGET_ADDRESS, 17'h1FFFF);
    write_reg(fip_pkg::REG_START_OFFSET, 17'h1FFFF);
    write_reg(fip_pkg::REG_FLASH_OPCODE, 17'h000FF);
    write_reg(fip_pkg::REG_CRC_OPCODE, 17'h1FF00);
    send_image_byte(8'h00, 1'b1);
    wait_idle();
  endtask

  task automatic test_nine_byte_image();
    logic [7:0] pattern [9];
    pattern = '{8'hFF, 8'hFF, 8'h00, 8'hC0, 8'h3F, 8'h80, 8'h01, 8'h7F, 8'hAA};
    write_reg(fip_pkg::REG_TARGET_ADDRESS, 17'h0);
    write_reg(fip_pkg::REG_START_OFFSET, 17'h0);
    write_reg(fip_pkg::REG_FLASH_OPCODE, 17'h0);
    write_reg(fip_pkg::REG_CRC_OPCODE, 17'h000FF);
    for (int i = 0; i < 9; i++) begin
      send_image_byte(pattern[i], i == 8);
    end
    wait_idle();
  endtask

  // New register values written part way through an image apply to the packets still to come.
  task automatic test_config_mid_image();
    send_image_byte(8'h55, 1'b0);
    send_image_byte(8'hFF, 1'b0);
    send_image_byte(8'h00, 1'b0);
    wait_idle();
    write_reg(fip_pkg::REG_START_OFFSET, fip_pkg::CFG_DATA_W'($urandom) | 17'h1);
    write_reg(fip_pkg::REG_TARGET_ADDRESS, pick_reg_value());
    write_reg(fip_pkg::REG_FLASH_OPCODE, pick_reg_value());
    write_reg(fip_pkg::REG_CRC_OPCODE, pick_reg_value());
    send_image_byte(8'hA5, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_images();
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 3) == 0) begin
        len = fip_pkg::BYTES_PER_PACKET * $urandom_range(1, fip_pkg::PACKETS_PER_ROW);
      end else begin
        len = $urandom_range(1, 40);
      end
      tx_fast = ($urandom_range(0, 3) == 0);
      rx_fast = ($urandom_range(0, 3) == 0);
      send_image(len);
      sent += len;
      // Otherwise the next image follows straight on.
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        write_reg(fip_pkg::REG_TARGET_ADDRESS + fip_pkg::CFG_IDX_W'($urandom_range(0, 3)),
                  pick_reg_value());
        if ($urandom_range(0, 1) == 0) begin
          write_reg(fip_pkg::REG_START_OFFSET, pick_reg_value());
        end
      end
    end
    wait_idle();
  endtask

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_single_byte_image();
    test_nine_byte_image();
    test_config_mid_image();
    test_random_images();
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
